### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each module that uses them has clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

### hw/rtl/mtde_pkg.sv
`timescale 1ns / 1ps

package mtde_pkg;

  // Field widths of the input and result beats.
  localparam int CMD_W  = 2;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 5;
  localparam int ELEM_W = 16;
  localparam int OCOL_W = 4;
  localparam int DOT_W  = 37;

  // Multiply-accumulate lanes and the widths inside the adder tree.
  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int PAIR_W = PROD_W + 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_BT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_a;      // write the incoming element into the A store
    logic wr_bt;     // write the incoming element into the transposed B store
    logic start;     // capture the row pair and clear the accumulator
    logic issue;     // read one chunk of LANES elements from both stores
    logic load_out;  // move the finished sum into the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_ok;        // load coordinates fall inside matrix A
    logic bt_ok;       // load coordinates fall inside transposed B
    logic cmp_ok;      // compute row and column fall inside the product
    logic last_chunk;  // the chunk being issued is the final one
    logic pipe_busy;   // reads or partial sums are still in flight
  } dp_status_t;

endpackage

### hw/rtl/mtde_ram.sv
`timescale 1ns / 1ps

module mtde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mtde_datapath.sv
`timescale 1ns / 1ps

module mtde_datapath
  import mtde_pkg::*;
#(
  parameter int A_ROWS = 16,
  parameter int K_DIM  = 32,
  parameter int B_ROWS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  output dp_status_t               sts_o,
  input  logic        [CMD_W-1:0]  in_cmd_i,
  input  logic        [ROW_W-1:0]  in_row_i,
  input  logic        [COL_W-1:0]  in_col_i,
  input  logic signed [ELEM_W-1:0] in_value_i,
  output logic        [ROW_W-1:0]  out_row_o,
  output logic        [OCOL_W-1:0] out_col_o,
  output logic signed [DOT_W-1:0]  dot_o
);

  `include "assert_macros.svh"

  // Each store is split into LANES banks; element k of a row sits in bank k % LANES.
  localparam int KCH     = (K_DIM + LANES - 1) / LANES;
  localparam int A_DEPTH = A_ROWS * KCH;
  localparam int B_DEPTH = B_ROWS * KCH;
  localparam int AAW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int BAW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int CW      = (KCH > 1) ? $clog2(KCH) : 1;
  localparam int NPAIR   = LANES / 2;

  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [CW-1:0]    chunk_q, chunk_d;

  logic [AAW-1:0] a_waddr, a_raddr;
  logic [BAW-1:0] b_waddr, b_raddr;
  logic [LANE_W-1:0] wr_lane;
  logic [LANES-1:0]  lane_en;

  logic [ELEM_W-1:0] a_rdata [LANES];
  logic [ELEM_W-1:0] b_rdata [LANES];

  logic                     rd_v_q, prod_v_q, pair_v_q;
  logic        [LANES-1:0]  rd_mask_q;
  logic signed [PROD_W-1:0] prod_q [LANES];
  logic signed [PROD_W-1:0] prod_d [LANES];
  logic signed [PAIR_W-1:0] pair_q [NPAIR];
  logic signed [PAIR_W-1:0] pair_d [NPAIR];
  logic signed [DOT_W-1:0]  acc_q, acc_d, chunk_sum;

  logic        [ROW_W-1:0]  out_row_q;
  logic        [OCOL_W-1:0] out_col_q;
  logic signed [DOT_W-1:0]  dot_q;

  // Range checks on the incoming beat.
  assign sts_o.a_ok   = (int'(in_row_i) < A_ROWS) && (int'(in_col_i) < K_DIM);
  assign sts_o.bt_ok  = (int'(in_row_i) < B_ROWS) && (int'(in_col_i) < K_DIM);
  assign sts_o.cmp_ok = (int'(in_row_i) < A_ROWS) && (int'(in_col_i) < B_ROWS);
  assign sts_o.last_chunk = (chunk_q == CW'(KCH - 1));
  assign sts_o.pipe_busy  = rd_v_q || prod_v_q || pair_v_q;

  // Write side: bank from the low column bits, row of the bank from the rest.
  assign wr_lane = in_col_i[LANE_W-1:0];
  assign a_waddr = AAW'(int'(in_row_i) * KCH + int'(in_col_i >> LANE_W));
  assign b_waddr = BAW'(int'(in_row_i) * KCH + int'(in_col_i >> LANE_W));

  // Read side: one chunk of LANES elements of each row per issue.
  assign a_raddr = AAW'(int'(row_q) * KCH + int'(chunk_q));
  assign b_raddr = BAW'(int'(col_q) * KCH + int'(chunk_q));

  // Lanes past the end of a row carry no term in the last chunk.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_en[l] = (int'(chunk_q) * LANES + l) < K_DIM;
    end
  end

  // Bank memories for both stores.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mtde_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (A_DEPTH)
    ) u_a_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.wr_a && (wr_lane == LANE_W'(l))),
      .waddr_i (a_waddr),
      .wdata_i (in_value_i),
      .raddr_i (a_raddr),
      .rdata_o (a_rdata[l])
    );

    mtde_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (B_DEPTH)
    ) u_b_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.wr_bt && (wr_lane == LANE_W'(l))),
      .waddr_i (b_waddr),
      .wdata_i (in_value_i),
      .raddr_i (b_raddr),
      .rdata_o (b_rdata[l])
    );
  end

  // One signed multiply per lane.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (rd_mask_q[l]) begin
        prod_d[l] = $signed(a_rdata[l]) * $signed(b_rdata[l]);
      end else begin
        prod_d[l] = '0;
      end
    end
  end

  // First level of the adder tree.
  always_comb begin
    for (int i = 0; i < NPAIR; i++) begin
      pair_d[i] = {prod_q[2*i][PROD_W-1], prod_q[2*i]} +
                  {prod_q[2*i+1][PROD_W-1], prod_q[2*i+1]};
    end
  end

  // Remaining pair sums folded into the accumulator.
  always_comb begin
    chunk_sum = '0;
    for (int i = 0; i < NPAIR; i++) begin
      chunk_sum = chunk_sum + {{(DOT_W - PAIR_W){pair_q[i][PAIR_W-1]}}, pair_q[i]};
    end
    acc_d = acc_q;
    if (cmd_i.start) begin
      acc_d = '0;
    end else if (pair_v_q) begin
      acc_d = acc_q + chunk_sum;
    end
  end

  // Chunk counter for the read sweep.
  always_comb begin
    chunk_d = chunk_q;
    if (cmd_i.start) begin
      chunk_d = '0;
    end else if (cmd_i.issue && !sts_o.last_chunk) begin
      chunk_d = chunk_q + CW'(1);
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      pair_v_q <= 1'b0;
      chunk_q  <= '0;
    end else begin
      rd_v_q   <= cmd_i.issue;
      prod_v_q <= rd_v_q;
      pair_v_q <= prod_v_q;
      chunk_q  <= chunk_d;
    end
  end

  // Payload registers of the pipeline and the result.
  always_ff @(posedge clk_i) begin
    rd_mask_q <= lane_en;
    for (int l = 0; l < LANES; l++) begin
      prod_q[l] <= prod_d[l];
    end
    for (int i = 0; i < NPAIR; i++) begin
      pair_q[i] <= pair_d[i];
    end
    acc_q <= acc_d;
    if (cmd_i.start) begin
      row_q <= in_row_i;
      col_q <= in_col_i;
    end
    if (cmd_i.load_out) begin
      out_row_q <= row_q;
      out_col_q <= col_q[OCOL_W-1:0];
      dot_q     <= acc_q;
    end
  end

  assign out_row_o = out_row_q;
  assign out_col_o = out_col_q;
  assign dot_o     = dot_q;

  // A load beat must never land while a dot product is in flight.
  `ASSERT_NEVER(a_no_write_in_flight, (cmd_i.wr_a || cmd_i.wr_bt) && sts_o.pipe_busy,
                "store written while a dot product is in flight")

  // Loads only happen for coordinates inside their matrix and the matching command.
  `ASSERT_CLK(a_write_legal, cmd_i.wr_a |-> (sts_o.a_ok && in_cmd_i == CMD_LOAD_A),
              "A store written with an illegal beat")

  // The same holds for the transposed B store.
  `ASSERT_CLK(a_bt_write_legal, cmd_i.wr_bt |-> (sts_o.bt_ok && in_cmd_i == CMD_LOAD_BT),
              "transposed B store written with an illegal beat")

endmodule

### hw/rtl/mtde_ctrl.sv
`timescale 1ns / 1ps

module mtde_ctrl
  import mtde_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] in_cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ctrl_cmd_t        cmd_o,
  input  dp_status_t       sts_i
);

  `include "assert_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Sequencer: take a beat, sweep the chunks, then wait for the pipeline to empty and the result register to be free.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.wr_a  = (in_cmd_i == CMD_LOAD_A) && sts_i.a_ok;
          cmd_o.wr_bt = (in_cmd_i == CMD_LOAD_BT) && sts_i.bt_ok;
          if ((in_cmd_i == CMD_COMPUTE) && sts_i.cmp_ok) begin
            cmd_o.start = 1'b1;
            state_d     = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_chunk) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy && (!out_valid_q || out_ready_i)) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A waiting result is never overwritten.
  `ASSERT_CLK(a_no_result_overwrite, cmd_o.load_out |-> (!out_valid_q || out_ready_i),
              "result register overwritten before it was taken")

  // The sum is only taken once every partial sum has reached the accumulator.
  `ASSERT_NEVER(a_load_when_drained, cmd_o.load_out && sts_i.pipe_busy,
                "result taken while partial sums were in flight")

  // The sweep stops right after the last chunk.
  `ASSERT_CLK(a_sweep_ends, (cmd_o.issue && sts_i.last_chunk) |=> !cmd_o.issue,
              "chunk read issued past the end of the row")

endmodule

### hw/rtl/matmul_transposed_dot_engine.sv
// Dot-product engine for a matrix product with B held transposed. Load beats (cmd 0 for A,
// cmd 1 for transposed B) write one signed 16-bit element each and produce no result;
// loads outside the matrix are dropped. A compute beat (cmd 2) names an A row and a
// transposed-B row and yields one result beat with the exact K_DIM-term dot product,
// wrapped to 37 bits, and the row pair; out-of-range computes and cmd 3 are dropped.
// Eight multiply-accumulate lanes read eight elements of each row per cycle from banked
// memories, so a compute occupies the input side while it is accepted, while one read is
// issued per chunk, and while the read, multiply and adder-tree stages drain. A finished
// result waits in an output register, so the next beat is accepted while it is still
// unread; a compute that reaches its last cycle while that result is still unread holds
// there until it is taken. Reading an element that was never loaded gives an undefined
// value.
`timescale 1ns / 1ps

module matmul_transposed_dot_engine
  import mtde_pkg::*;
#(
  parameter int A_ROWS = 16,
  parameter int K_DIM  = 32,
  parameter int B_ROWS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic        [CMD_W-1:0]  cmd_i,
  input  logic        [ROW_W-1:0]  row_i,
  input  logic        [COL_W-1:0]  col_i,
  input  logic signed [ELEM_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic        [ROW_W-1:0]  out_row_o,
  output logic        [OCOL_W-1:0] out_col_o,
  output logic signed [DOT_W-1:0]  dot_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequencer.
  mtde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_cmd_i    (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Stores, lanes and accumulator.
  mtde_datapath #(
    .A_ROWS (A_ROWS),
    .K_DIM  (K_DIM),
    .B_ROWS (B_ROWS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_cmd_i   (cmd_i),
    .in_row_i   (row_i),
    .in_col_i   (col_i),
    .in_value_i (value_i),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .dot_o      (dot_o)
  );

endmodule
